@@ design/swp95_pkg.sv @@
// Shared types and constants for the sliding-window 95th-percentile core.
// No dependencies; every other design file refers to this package by scoped names.
package swp95_pkg;

    localparam int unsigned SAMPLE_W    = 32;
    localparam int unsigned VALID_W     = 7;

    // Percentile index is ceil(95 * n / 100) - 1, computed as (n * 95 + 99) / 100 - 1.
    localparam int unsigned PCT_NUM     = 95;
    localparam int unsigned PCT_ROUND   = 99;
    // Division by 100: multiply by 5243 and shift right by 19. The result is exact
    // for every dividend below 43000, which covers windows up to 256 samples.
    localparam int unsigned RECIP_MUL   = 5243;
    localparam int unsigned RECIP_SHIFT = 19;

    // One position of the sorted chain.
    typedef struct packed {
        logic                occ;
        logic [SAMPLE_W-1:0] value;
    } slot_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic                remove;
        logic                insert;
        logic [SAMPLE_W-1:0] key;
    } cell_ctrl_t;

endpackage

@@ design/swp95_cell.sv @@
// One cell of the sorted chain: holds one sample and its occupied flag.
// Depends on swp95_pkg for the slot and control types.
module swp95_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swp95_pkg::cell_ctrl_t ctrl,
    input  swp95_pkg::slot_t      left,
    input  swp95_pkg::slot_t      right,
    output swp95_pkg::slot_t      slot
);

    logic                          occ_reg;
    logic                          occ_next;
    logic [swp95_pkg::SAMPLE_W-1:0] value_reg;
    logic [swp95_pkg::SAMPLE_W-1:0] value_next;

    // The chain is sorted ascending and empty cells sit at the top end, so every
    // decision needs only this cell and its two neighbors.
    always_comb begin
        occ_next   = occ_reg;
        value_next = value_reg;
        if (ctrl.remove) begin
            // All cells at or above the first copy of the key move down by one.
            if (occ_reg && (value_reg >= ctrl.key)) begin
                occ_next   = right.occ;
                value_next = right.value;
            end
        end else if (ctrl.insert) begin
            if (left.occ && (left.value > ctrl.key)) begin
                occ_next   = 1'b1;
                value_next = left.value;
            end else if (left.occ && (!occ_reg || (value_reg > ctrl.key))) begin
                occ_next   = 1'b1;
                value_next = ctrl.key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign slot.occ   = occ_reg;
    assign slot.value = value_reg;

endmodule

@@ design/swp95_chain.sv @@
// Row of sorted cells with the percentile read port.
// Depends on swp95_pkg and swp95_cell.
module swp95_chain #(
    parameter  int unsigned DEPTH = 64,
    localparam int unsigned IDX_W = $clog2(DEPTH)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  swp95_pkg::cell_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]               sel_idx,
    output logic [swp95_pkg::SAMPLE_W-1:0] sel_value
);

    swp95_pkg::slot_t slots [DEPTH];
    swp95_pkg::slot_t lefts [DEPTH];
    swp95_pkg::slot_t rights[DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            // The bottom cell sees an occupied zero below it, so it takes the key whenever it is
            // empty or holds a larger value; the top cell sees an empty slot above it.
            if (i == 0) begin : g_bottom
                assign lefts[i].occ   = 1'b1;
                assign lefts[i].value = '0;
            end else begin : g_left
                assign lefts[i] = slots[i-1];
            end
            if (i == DEPTH - 1) begin : g_top
                assign rights[i].occ   = 1'b0;
                assign rights[i].value = '0;
            end else begin : g_right
                assign rights[i] = slots[i+1];
            end

            swp95_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .left    (lefts[i]),
                .right   (rights[i]),
                .slot    (slots[i])
            );
        end
    endgenerate

    assign sel_value = slots[sel_idx].value;

endmodule

@@ design/sliding_window_p95_latency_core.sv @@
// Top level of the sliding-window 95th-percentile latency core.
// Depends on swp95_pkg and swp95_chain (which uses swp95_cell).
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_valid / s_ready  | s_latency_sample[31:0]
//  m_       | out       | m_valid / m_ready  | m_p95_value[31:0], m_valid_samples[6:0]
//
// Each transaction steps through idle, evict, insert and select: the accept writes the ring
// memory and reads the sample that leaves the window, evict removes it from the sorted cell
// chain once the window is full, insert places the new sample, and select loads the percentile
// cell into the output register; the chain takes one operation per cycle. Reset (aresetn low
// at a clock edge) empties the window and the output register with no clearing pass. A result
// waiting on m_ready does not block the next input; only the select step waits for the output.
module sliding_window_p95_latency_core #(
    parameter int unsigned WINDOW_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [swp95_pkg::SAMPLE_W-1:0] s_latency_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [swp95_pkg::SAMPLE_W-1:0] m_p95_value,
    output logic [swp95_pkg::VALID_W-1:0]  m_valid_samples
);

    localparam int unsigned PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
    // Width of n * 95 + 99, which stays below 128 * 2**CNT_W because n < 2**CNT_W.
    localparam int unsigned X_W    = CNT_W + 7;
    localparam int unsigned PROD_W = X_W + 14;
    localparam int unsigned EXT_W  = CNT_W + swp95_pkg::VALID_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVICT  = 4'b0010,
        ST_INSERT = 4'b0100,
        ST_SELECT = 4'b1000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [PTR_W-1:0]                wr_pos_reg;
    logic [CNT_W-1:0]                count_reg;
    logic                            full_reg;
    logic [swp95_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [swp95_pkg::SAMPLE_W-1:0]  evict_reg;
    logic [X_W-1:0]                  x_reg;
    logic [PTR_W-1:0]                idx_reg;
    logic                            m_valid_reg;
    logic [swp95_pkg::SAMPLE_W-1:0]  p95_reg;
    logic [swp95_pkg::VALID_W-1:0]   vs_reg;

    logic                            s_accept;
    logic                            out_load;
    logic [PROD_W-1:0]               prod;
    logic [PROD_W-1:0]               idx_wide;
    logic [EXT_W-1:0]                count_ext;
    logic [swp95_pkg::SAMPLE_W-1:0]  sel_value;
    swp95_pkg::cell_ctrl_t           ctrl;

    // Ring of the most recent samples. The entry at the write position is read
    // before it is overwritten; its old value matters only once the window is full,
    // by which time every entry has been written.
    logic [swp95_pkg::SAMPLE_W-1:0]  ring_mem [WINDOW_DEPTH];

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_load = (state_reg == ST_SELECT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ring_mem[wr_pos_reg] <= s_latency_sample;
            evict_reg            <= ring_mem[wr_pos_reg];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_EVICT;
            ST_EVICT:  state_next = ST_INSERT;
            ST_INSERT: state_next = ST_SELECT;
            ST_SELECT: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state: FSM state, write position, fill count, full flag and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_pos_reg  <= '0;
            count_reg   <= '0;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                full_reg <= (count_reg == CNT_W'(WINDOW_DEPTH));
                if (count_reg != CNT_W'(WINDOW_DEPTH)) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (wr_pos_reg == PTR_W'(WINDOW_DEPTH - 1)) begin
                    wr_pos_reg <= '0;
                end else begin
                    wr_pos_reg <= wr_pos_reg + PTR_W'(1);
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Percentile index: the count is already final once the accept has been registered, so
    // n * 95 + 99 is formed during the evict step and divided by 100 during insert.
    assign prod     = PROD_W'(x_reg) * PROD_W'(swp95_pkg::RECIP_MUL);
    assign idx_wide = (prod >> swp95_pkg::RECIP_SHIFT) - PROD_W'(1);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_latency_sample;
        end
        if (state_reg == ST_EVICT) begin
            x_reg <= X_W'(count_reg) * X_W'(swp95_pkg::PCT_NUM)
                     + X_W'(swp95_pkg::PCT_ROUND);
        end
        if (state_reg == ST_INSERT) begin
            idx_reg <= idx_wide[PTR_W-1:0];
        end
    end

    // Removal in the evict step happens only on a full window; it takes out one copy of the
    // old sample, and the insert step places the new sample after equal values.
    assign ctrl.remove = (state_reg == ST_EVICT) && full_reg;
    assign ctrl.insert = (state_reg == ST_INSERT);
    assign ctrl.key    = (state_reg == ST_EVICT) ? evict_reg : sample_reg;

    swp95_chain #(
        .DEPTH (WINDOW_DEPTH)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sel_idx   (idx_reg),
        .sel_value (sel_value)
    );

    // The sample count is reported in seven bits; wider counts keep their low bits.
    assign count_ext = EXT_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            p95_reg <= sel_value;
            vs_reg  <= count_ext[swp95_pkg::VALID_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_p95_value     = p95_reg;
    assign m_valid_samples = vs_reg;

endmodule

@@ verif/swp95_checker.sv @@
`timescale 1ns / 1ps
// Checker for the sliding-window 95th-percentile core: watches both channels,
// predicts each result and compares it field by field. Depends on swp95_pkg.
module swp95_checker #(
    parameter int unsigned WINDOW_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [swp95_pkg::SAMPLE_W-1:0] s_latency_sample,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [swp95_pkg::SAMPLE_W-1:0] m_p95_value,
    input  logic [swp95_pkg::VALID_W-1:0]  m_valid_samples,
    output int unsigned                    err_count,
    output int unsigned                    results_seen,
    output int unsigned                    pending
);

    localparam int unsigned PCT_NUMERATOR = 95;
    localparam int unsigned PCT_CEIL_ADD  = 99;
    localparam int unsigned PCT_DIVISOR   = 100;

    typedef struct packed {
        logic [swp95_pkg::SAMPLE_W-1:0] p95_value;
        logic [swp95_pkg::VALID_W-1:0]  valid_samples;
    } window_stat_t;

    // Shadow of the window: arrival order and value order.
    logic [swp95_pkg::SAMPLE_W-1:0] arrival_ring [WINDOW_DEPTH];
    logic [swp95_pkg::SAMPLE_W-1:0] ranked_window [WINDOW_DEPTH];
    int unsigned                    next_slot;
    int unsigned                    held;

    window_stat_t expected_stats[$];
    int unsigned  mismatch_total;
    int unsigned  result_total;

    assign err_count    = mismatch_total;
    assign results_seen = result_total;

    // Adds one sample to the shadow window and returns the percentile and sample count it yields.
    task automatic admit_sample(input logic [swp95_pkg::SAMPLE_W-1:0] sample,
                                output window_stat_t stat);
        bit          found;
        int unsigned rank;
        int unsigned pick;
        found = 1'b0;
        if (held == WINDOW_DEPTH) begin
            // Evict exactly one copy of the oldest value, closing the gap it leaves.
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                if (!found && ranked_window[i] == arrival_ring[next_slot])
                    found = 1'b1;
                if (found)
                    ranked_window[i] = ranked_window[i + 1];
            end
            held--;
        end
        // New value goes after any equal values already present.
        rank = held;
        while (rank > 0 && ranked_window[rank - 1] > sample) begin
            ranked_window[rank] = ranked_window[rank - 1];
            rank--;
        end
        ranked_window[rank] = sample;
        held++;
        arrival_ring[next_slot] = sample;
        next_slot = (next_slot + 1) % WINDOW_DEPTH;

        pick = (held * PCT_NUMERATOR + PCT_CEIL_ADD) / PCT_DIVISOR - 1;
        if (pick >= held)
            pick = held - 1;
        stat.p95_value     = ranked_window[pick];
        stat.valid_samples = swp95_pkg::VALID_W'(held);
    endtask

    always @(posedge aclk) begin : monitor
        window_stat_t want;
        window_stat_t stat;
        if (!aresetn) begin
            next_slot = 0;
            held      = 0;
            expected_stats.delete();
            mismatch_total = 0;
            result_total   = 0;
            pending <= 0;
        end else begin
            // Results are checked before this edge's input is predicted, so an early
            // result cannot pair with a sample accepted in the same cycle.
            if (m_valid && m_ready) begin
                result_total++;
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result p95 %0d count %0d", $time,
                             m_p95_value, m_valid_samples);
                    mismatch_total++;
                end else begin
                    want = expected_stats.pop_front();
                    if (m_p95_value !== want.p95_value) begin
                        $display("%0t: p95_value expected %0d actual %0d", $time,
                                 want.p95_value, m_p95_value);
                        mismatch_total++;
                    end
                    if (m_valid_samples !== want.valid_samples) begin
                        $display("%0t: valid_samples expected %0d actual %0d", $time,
                                 want.valid_samples, m_valid_samples);
                        mismatch_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                admit_sample(s_latency_sample, stat);
                expected_stats.push_back(stat);
            end
            pending <= expected_stats.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the testbench for sliding_window_p95_latency_core: clock, reset and stimulus.
// Depends on swp95_pkg, the core and swp95_checker, which does all result checking.
module tb_top;

    // The slowest legal run is the core work for each sample plus random stalls on
    // both sides; this bound is many times that for about 600 samples.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 550;
    localparam int unsigned IDLE_PCT     = 6;
    // Samples within this range carry no idling on either side.
    localparam int unsigned STEADY_FIRST = 150;
    localparam int unsigned STEADY_LAST  = 300;
    // Extra cycles waited after the final drain, more than one core transaction takes.
    localparam int unsigned DRAIN_CYCLES = 12;

    // Value classes used to build the random samples.
    typedef enum int unsigned {
        SMALL_POOL,
        FULL_RANGE,
        EXTREME,
        NEAR_MAX,
        REPEAT_LAST
    } sample_class_t;

    logic                           aclk             = 1'b0;
    logic                           aresetn          = 1'b0;
    logic                           s_valid          = 1'b0;
    logic                           s_ready;
    logic [swp95_pkg::SAMPLE_W-1:0] s_latency_sample = '0;
    logic                           m_valid;
    logic                           m_ready          = 1'b0;
    logic [swp95_pkg::SAMPLE_W-1:0] m_p95_value;
    logic [swp95_pkg::VALID_W-1:0]  m_valid_samples;

    // Set by the stimulus process while both sides must run without idling.
    logic                           steady           = 1'b0;

    int unsigned err_count;
    int unsigned results_seen;
    int unsigned pending;
    int unsigned cycle_count = 0;
    int unsigned samples_sent = 0;

    always #4 aclk = ~aclk;

    sliding_window_p95_latency_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_latency_sample(s_latency_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_p95_value     (m_p95_value),
        .m_valid_samples (m_valid_samples)
    );

    swp95_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_latency_sample(s_latency_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_p95_value     (m_p95_value),
        .m_valid_samples (m_valid_samples),
        .err_count       (err_count),
        .results_seen    (results_seen),
        .pending         (pending)
    );

    // The result side stalls at random, except while the steady window is open.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    // Watchdog: a run that hangs anywhere ends here as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles with %0d results pending", $time,
                     CYCLE_LIMIT, pending);
            $display("[sliding_window_p95_latency_core] ERROR");
            $finish;
        end
    end

    // Presents one sample and holds it until the core takes the transaction.
    // Called at a rising edge; returns at the edge where the sample was accepted.
    task automatic send_sample(input logic [swp95_pkg::SAMPLE_W-1:0] sample);
        s_valid          <= 1'b1;
        s_latency_sample <= sample;
        do
            @(posedge aclk);
        while (!s_ready);
        samples_sent++;
    endtask

    // Random gaps on the input side, skipped while the steady window is open.
    task automatic maybe_idle();
        while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Stops sending until every outstanding result has come back.
    task automatic drain_window();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
    endtask

    initial begin : stimulus
        logic [swp95_pkg::SAMPLE_W-1:0] directed_samples[$];
        logic [swp95_pkg::SAMPLE_W-1:0] last_sample;
        logic [swp95_pkg::SAMPLE_W-1:0] sample;
        sample_class_t                  kind;

        // Extremes, alternating bit patterns, then runs of equal values so that the
        // window holds duplicates which later leave it one copy at a time.
        directed_samples = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                             32'd5, 32'd5, 32'd5, 32'h0000_0000, 32'hFFFF_FFFF,
                             32'd3, 32'd7, 32'd5, 32'd1, 32'd9, 32'd5, 32'hFFFF_FFFF};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_samples[i]) begin
            maybe_idle();
            send_sample(directed_samples[i]);
        end
        last_sample = directed_samples[directed_samples.size() - 1];
        drain_window();

        // Random part: the window fills, wraps and keeps evicting. A small value pool
        // makes duplicate evictions common; full-range values toggle every bit.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == STEADY_FIRST)
                steady <= 1'b1;
            else if (n == STEADY_LAST)
                steady <= 1'b0;
            if (n == 100 || n == 400)
                drain_window();
            maybe_idle();
            kind = sample_class_t'($urandom_range(REPEAT_LAST, SMALL_POOL));
            case (kind)
                SMALL_POOL:  sample = $urandom_range(15, 0);
                FULL_RANGE:  sample = $urandom;
                EXTREME:     sample = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
                NEAR_MAX:    sample = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF00);
                default:     sample = last_sample;
            endcase
            send_sample(sample);
            last_sample = sample;
        end
        s_valid <= 1'b0;

        // Every sample is in; let the remaining results drain, then wait out DRAIN_CYCLES
        // so that any spurious extra result is still caught by the checker.
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d latency samples (extremes, duplicates, window wrap);", samples_sent);
        $display("checked %0d percentile results, %0d mismatches.", results_seen, err_count);
        if (err_count == 0) begin
            $display("[sliding_window_p95_latency_core] OK");
        end else begin
            $display("[sliding_window_p95_latency_core] ERROR");
        end
        $finish;
    end

endmodule
